@@ hw/rtl/morse_code_codec_macros.svh @@
// Assertion macros shared by the Morse code codec RTL.
`ifndef MORSE_CODE_CODEC_MACROS_SVH
`define MORSE_CODE_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MCC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mcc_pkg.sv @@
// Package of the Morse code codec: character codes, code table, job type and lookups.
package mcc_pkg;

    // Mode register codes.
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // ASCII codes used by the codec.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_SEP     = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_STEP  = 8'h20;

    // Longest path and saturation limit of the token length.
    localparam int MaxPath = 7;
    localparam logic [3:0] TOKEN_LEN_MAX = 4'd15;

    localparam int TableSize = 53;

    // Table characters. Bit i of a code is 1 when symbol i is a dash.
    localparam logic [7:0] CODE_CHAR [TableSize] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h31, 8'h32, 8'h33, 8'h34,
        8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2E, 8'h2C, 8'h3F, 8'h2F,
        8'h27, 8'h21, 8'h3B, 8'h3A, 8'h2B, 8'h2D, 8'h3D, 8'h28, 8'h29, 8'h5F,
        8'h24, 8'h22, 8'h40
    };

    localparam logic [2:0] CODE_LEN [TableSize] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd6, 3'd5, 3'd5, 3'd6, 3'd6,
        3'd7, 3'd6, 3'd6
    };

    localparam logic [6:0] CODE_BITS [TableSize] = '{
        7'b0000010, 7'b0000001, 7'b0000101, 7'b0000001, 7'b0000000,
        7'b0000100, 7'b0000011, 7'b0000000, 7'b0000000, 7'b0001110,
        7'b0000101, 7'b0000010, 7'b0000011, 7'b0000001, 7'b0000111,
        7'b0000110, 7'b0001011, 7'b0000010, 7'b0000000, 7'b0000001,
        7'b0000100, 7'b0001000, 7'b0000110, 7'b0001001, 7'b0001101,
        7'b0000011, 7'b0011110, 7'b0011100, 7'b0011000, 7'b0010000,
        7'b0000000, 7'b0000001, 7'b0000011, 7'b0000111, 7'b0001111,
        7'b0011111, 7'b0101010, 7'b0110011, 7'b0001100, 7'b0001001,
        7'b0011110, 7'b0110101, 7'b0010101, 7'b0000111, 7'b0001010,
        7'b0100001, 7'b0010001, 7'b0001101, 7'b0101101, 7'b0101100,
        7'b1001000, 7'b0010010, 7'b0010110
    };

    // One code looked up by character.
    typedef struct packed {
        logic       found;
        logic [2:0] len;
        logic [6:0] bits;
    } t_code;

    // Job passed from the front part to the back part: an optional
    // leading byte, then either one literal byte or a string of symbols.
    typedef struct packed {
        logic       pre_en;
        logic [7:0] pre_byte;
        logic       body_en;
        logic       body_sym;
        logic [7:0] body_byte;
        logic [6:0] sym_bits;
        logic [3:0] count;
        logic       last;
    } t_job;

    // Character at the end of a dot/dash path: a table character, NUL for an
    // inner node without a character, or '?' for a path off the table.
    function automatic logic [7:0] decode_path(input logic [2:0] len, input logic [6:0] bits);
        logic [7:0] res;
        logic       inner;
        logic       exact;
        logic [6:0] mask;
        res   = CH_QUERY;
        inner = 1'b0;
        exact = 1'b0;
        mask  = 7'((8'd1 << len) - 8'd1);
        for (int k = 0; k < TableSize; k++) begin
            if (CODE_LEN[k] >= len && ((CODE_BITS[k] ^ bits) & mask) == 7'd0) begin
                if (CODE_LEN[k] == len) begin
                    res   = CODE_CHAR[k];
                    exact = 1'b1;
                end else begin
                    inner = 1'b1;
                end
            end
        end
        if (!exact && inner) begin
            res = CH_NUL;
        end
        return res;
    endfunction

    // Character of a whole token.
    function automatic logic [7:0] token_char(input logic [3:0] len, input logic [6:0] bits,
                                              input logic bad, input logic is_space);
        logic [7:0] res;
        if (is_space && len == 4'd1) begin
            res = CH_SPACE;
        end else if (bad) begin
            res = CH_QUERY;
        end else begin
            res = decode_path(len[2:0], bits);
        end
        return res;
    endfunction

    // Code of a text character, if it has one.
    function automatic t_code encode_char(input logic [7:0] c);
        t_code res;
        res = '0;
        for (int k = 0; k < TableSize; k++) begin
            if (CODE_CHAR[k] == c) begin
                res.found = 1'b1;
                res.len   = CODE_LEN[k];
                res.bits  = CODE_BITS[k];
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/mcc_if.sv @@
// Channel interfaces of the Morse code codec: input bytes, result bytes, mode writes.
interface mcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface mcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_byte, output run_end, output message_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_end, input message_end,
                  output ready);
endinterface

interface mcc_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

@@ hw/rtl/mcc_front.sv @@
// Front part of the Morse code codec: accepts bytes, keeps token state, builds jobs.
module mcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcc_in_if.sink        i_in,
    mcc_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output mcc_pkg::t_job o_job
);

    logic       r_mode;
    logic [3:0] r_len;
    logic [6:0] r_bits;
    logic       r_bad;
    logic       r_sp;
    logic       r_prev;

    logic [3:0] n_len;
    logic [6:0] n_bits;
    logic       n_bad;
    logic       n_sp;
    logic       n_prev;

    logic          accept;
    logic          has_result;
    mcc_pkg::t_job job;
    logic [7:0]    b;
    logic [7:0]    c;
    logic          is_sep;
    logic          is_sym;
    logic [3:0]    upd_len;
    logic [6:0]    upd_bits;
    logic          upd_bad;
    logic          upd_sp;
    logic [7:0]    cur_char;
    logic [7:0]    upd_char;
    mcc_pkg::t_code code;

    // Mode writes are taken whenever reset is not held.
    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && !i_q_full;
    assign accept      = i_in.valid && i_in.ready;
    assign o_push      = accept && has_result;
    assign o_job       = job;

    // Token update for a byte that does not close the token.
    assign b        = i_in.in_byte;
    assign is_sep   = (b == mcc_pkg::CH_SEP);
    assign is_sym   = (b == mcc_pkg::CH_DOT) || (b == mcc_pkg::CH_DASH);
    assign upd_len  = (r_len < mcc_pkg::TOKEN_LEN_MAX) ? r_len + 4'd1 : r_len;
    assign upd_sp   = (r_len == 4'd0) && (b == mcc_pkg::CH_SPACE);
    assign upd_bad  = r_bad || !is_sym || (r_len >= 4'(mcc_pkg::MaxPath));
    assign upd_bits = (is_sym && b == mcc_pkg::CH_DASH && r_len < 4'(mcc_pkg::MaxPath))
                      ? (r_bits | 7'((8'd1 << r_len[2:0]))) : r_bits;
    assign cur_char = mcc_pkg::token_char(r_len, r_bits, r_bad, r_sp);
    assign upd_char = mcc_pkg::token_char(upd_len, upd_bits, upd_bad, upd_sp);

    // Text byte folded to upper case, and its code.
    always_comb begin
        c = b;
        if (b inside {[mcc_pkg::CH_LOWER_A:mcc_pkg::CH_LOWER_Z]}) begin
            c = b - mcc_pkg::CASE_STEP;
        end
    end
    assign code = mcc_pkg::encode_char(c);

    // Classification of the byte into a job and the next token state.
    always_comb begin
        n_len      = r_len;
        n_bits     = r_bits;
        n_bad      = r_bad;
        n_sp       = r_sp;
        n_prev     = r_prev;
        job        = '0;
        has_result = 1'b0;
        job.last   = i_in.last;
        if (r_mode == mcc_pkg::MODE_DECODE) begin
            if (is_sep) begin
                job.pre_en   = 1'b1;
                job.pre_byte = cur_char;
                has_result   = 1'b1;
                n_len        = '0;
                n_bits       = '0;
                n_bad        = 1'b0;
                n_sp         = 1'b0;
                if (i_in.last) begin
                    job.body_en   = 1'b1;
                    job.body_byte = mcc_pkg::token_char(4'd0, 7'd0, 1'b0, 1'b0);
                end
            end else begin
                n_len  = upd_len;
                n_bits = upd_bits;
                n_bad  = upd_bad;
                n_sp   = upd_sp;
                if (i_in.last) begin
                    job.body_en   = 1'b1;
                    job.body_byte = upd_char;
                    has_result    = 1'b1;
                    n_len         = '0;
                    n_bits        = '0;
                    n_bad         = 1'b0;
                    n_sp          = 1'b0;
                end
            end
        end else begin
            has_result  = 1'b1;
            job.body_en = 1'b1;
            if (c == mcc_pkg::CH_SPACE) begin
                job.body_byte = mcc_pkg::CH_SPACE;
                n_prev        = 1'b0;
            end else begin
                job.pre_en   = r_prev;
                job.pre_byte = mcc_pkg::CH_SEP;
                if (code.found) begin
                    job.body_sym = 1'b1;
                    job.sym_bits = code.bits;
                end else begin
                    job.body_byte = mcc_pkg::CH_QUERY;
                end
                n_prev = 1'b1;
            end
            if (i_in.last) begin
                n_prev = 1'b0;
            end
        end
        job.count = 4'(job.pre_en)
                  + (job.body_en ? (job.body_sym ? {1'b0, code.len} : 4'd1) : 4'd0);
    end

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mcc_pkg::MODE_DECODE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mode <= i_cfg.mode;
        end
    end

    // Token state, updated on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_bits <= '0;
            r_bad  <= 1'b0;
            r_sp   <= 1'b0;
            r_prev <= 1'b0;
        end else if (accept) begin
            r_len  <= n_len;
            r_bits <= n_bits;
            r_bad  <= n_bad;
            r_sp   <= n_sp;
            r_prev <= n_prev;
        end
    end

endmodule

@@ hw/rtl/mcc_queue.sv @@
// Two-entry job queue between the front and back parts of the Morse code codec.
`include "morse_code_codec_macros.svh"

module mcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mcc_pkg::t_job o_head
);

    mcc_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `MCC_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue overflow")
    `MCC_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")
    `MCC_ASSERT_IMPLIES(a_ptr_match, i_clk, i_rst_n, o_empty || o_full, r_wr_ptr == r_rd_ptr,
                        "queue pointers disagree with count")

endmodule

@@ hw/rtl/mcc_back.sv @@
// Back part of the Morse code codec: steps through each job and drives the result register.
`include "morse_code_codec_macros.svh"

module mcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  mcc_pkg::t_job i_head,
    output logic          o_pop,
    mcc_out_if.source     o_out
);

    logic [2:0] r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_msg_end;

    logic       load;
    logic       is_final;
    logic [2:0] sym_idx;
    logic [7:0] res_byte;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.run_end     = r_run_end;
    assign o_out.message_end = r_msg_end;

    // A result moves into the output register when it is empty or being drained.
    assign load     = !i_q_empty && (!r_valid || o_out.ready);
    assign is_final = ({1'b0, r_pos} == i_head.count - 4'd1);
    assign o_pop    = load && is_final;
    assign sym_idx  = r_pos - 3'(i_head.pre_en);

    // Byte at the current position of the job.
    always_comb begin
        if (i_head.pre_en && r_pos == 3'd0) begin
            res_byte = i_head.pre_byte;
        end else if (i_head.body_sym) begin
            res_byte = i_head.sym_bits[sym_idx] ? mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
        end else begin
            res_byte = i_head.body_byte;
        end
    end

    // Position within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (load) begin
            r_pos <= is_final ? 3'd0 : r_pos + 3'd1;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= res_byte;
            r_run_end <= is_final;
            r_msg_end <= is_final && i_head.last;
        end
    end

    `MCC_ASSERT_IMPLIES(a_pos_in_job, i_clk, i_rst_n, r_pos != 3'd0, !i_q_empty,
                        "job position set without a pending job")
    `MCC_ASSERT_NEXT(a_pos_wraps, i_clk, i_rst_n, o_pop, r_pos == 3'd0,
                     "job position did not return to start")
    `MCC_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_valid && !o_out.ready,
                     r_valid && $stable(r_byte) && $stable(r_pos),
                     "result changed while stalled")

endmodule

@@ hw/rtl/morse_code_codec.sv @@
// Top level of the Morse code codec: front part, job queue and back part.
//
//   Channel   Direction  Payload                              Transaction
//   i_in      in         in_byte[7:0], last                   valid && ready
//   o_out     out        out_byte[7:0], run_end, message_end  valid && ready
//   i_cfg     in         mode                                 valid && ready
//
// Decoding gives one result byte per closed token, two for a separator that ends a message.
// Encoding gives one to eight result bytes per character. The back sequencer emits one
// byte per cycle into the output register whenever that register is empty or being drained.
// i_rst_n is synchronous and active low; it clears mode, token state and the queue.
// A two-entry job queue lets the input keep flowing while the output is stalled;
// i_in.ready drops only when the queue is full or reset is held.
module morse_code_codec (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcc_in_if.sink    i_in,
    mcc_cfg_if.sink   i_cfg,
    mcc_out_if.source o_out
);

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    mcc_pkg::t_job push_job;
    mcc_pkg::t_job head_job;

    // Byte classification and token state.
    mcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Job queue.
    mcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // Result sequencing and output register.
    mcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the Morse code codec: directed and random messages in both modes.
`timescale 1ns / 100ps

// One result byte as it appears on the output channel.
typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;
} t_morse_result;

// Tracks the codec state, predicts the results of each accepted byte and checks
// every result transaction against the oldest prediction.
class t_morse_scoreboard;
    // Code table: the character at position k of symbols has the code codes[k].
    string symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890.,?/'!;:+-=()_$\"@";
    string codes [53] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
        "....-", ".....", "-....", "--...", "---..", "----.", "-----", ".-.-.-",
        "--..--", "..--..", "-..-.", ".----.", "-.-.--", "-.-.-.", "---...",
        ".-.-.", "-....-", "-...-", "-.--.", "-.--.-", "..--.-", "...-..-",
        ".-..-.", ".--.-."
    };

    logic       mode;
    logic [3:0] tok_len;
    logic [6:0] tok_path;
    logic       tok_bad;
    logic       tok_space;
    logic       after_char;
    int         errors;

    t_morse_result expected_q [$];
    t_morse_result batch [$];

    function new();
        mode       = mcc_pkg::MODE_DECODE;
        after_char = 1'b0;
        errors     = 0;
        clear_token();
    endfunction

    function void clear_token();
        tok_len   = 4'd0;
        tok_path  = 7'd0;
        tok_bad   = 1'b0;
        tok_space = 1'b0;
    endfunction

    function void set_mode(logic m);
        mode = m;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void add_byte(logic [7:0] b);
        t_morse_result r;
        r.out_byte    = b;
        r.run_end     = 1'b0;
        r.message_end = 1'b0;
        batch.push_back(r);
    endfunction

    // Walks the code table along a dot/dash path: an exact code gives its
    // character, a prefix of longer codes only gives NUL, anything else '?'.
    function logic [7:0] path_char(int len, logic [6:0] path);
        logic inner;
        logic hit;
        int   cl;
        inner = 1'b0;
        for (int k = 0; k < 53; k++) begin
            cl = codes[k].len();
            if (cl >= len) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if ((codes[k].getc(i) == mcc_pkg::CH_DASH) != path[i]) begin
                        hit = 1'b0;
                    end
                end
                if (hit && cl == len) begin
                    return symbols.getc(k);
                end
                if (hit) begin
                    inner = 1'b1;
                end
            end
        end
        return inner ? mcc_pkg::CH_NUL : mcc_pkg::CH_QUERY;
    endfunction

    function logic [7:0] token_char();
        if (tok_space && tok_len == 4'd1) begin
            return mcc_pkg::CH_SPACE;
        end
        if (tok_bad) begin
            return mcc_pkg::CH_QUERY;
        end
        return path_char(int'(tok_len), tok_path);
    endfunction

    // Notes one accepted input byte and queues the results it causes.
    function int note_byte(logic [7:0] b, logic last);
        logic [7:0] c;
        int         idx;
        batch.delete();
        if (mode == mcc_pkg::MODE_DECODE) begin
            if (b == mcc_pkg::CH_SEP) begin
                add_byte(token_char());
                clear_token();
            end else begin
                tok_space = (tok_len == 4'd0 && b == mcc_pkg::CH_SPACE);
                if (b == mcc_pkg::CH_DOT || b == mcc_pkg::CH_DASH) begin
                    if (tok_len < 4'(mcc_pkg::MaxPath)) begin
                        if (b == mcc_pkg::CH_DASH) begin
                            tok_path[tok_len[2:0]] = 1'b1;
                        end
                    end else begin
                        tok_bad = 1'b1;
                    end
                end else begin
                    tok_bad = 1'b1;
                end
                if (tok_len != mcc_pkg::TOKEN_LEN_MAX) begin
                    tok_len = tok_len + 4'd1;
                end
            end
            if (last) begin
                add_byte(token_char());
                clear_token();
            end
        end else begin
            c = b;
            if (c >= mcc_pkg::CH_LOWER_A && c <= mcc_pkg::CH_LOWER_Z) begin
                c = c - mcc_pkg::CASE_STEP;
            end
            if (c == mcc_pkg::CH_SPACE) begin
                add_byte(mcc_pkg::CH_SPACE);
                after_char = 1'b0;
            end else begin
                if (after_char) begin
                    add_byte(mcc_pkg::CH_SEP);
                end
                idx = -1;
                if (c != mcc_pkg::CH_NUL) begin
                    for (int k = 0; k < 53; k++) begin
                        if (idx < 0 && symbols.getc(k) == c) begin
                            idx = k;
                        end
                    end
                end
                if (idx < 0) begin
                    add_byte(mcc_pkg::CH_QUERY);
                end else begin
                    for (int i = 0; i < codes[idx].len(); i++) begin
                        add_byte(codes[idx].getc(i));
                    end
                end
                after_char = 1'b1;
            end
            if (last) begin
                after_char = 1'b0;
            end
        end
        // Flag the final result of this byte, and of the message if it ends here.
        if (batch.size() > 0) begin
            batch[batch.size() - 1].run_end = 1'b1;
            batch[batch.size() - 1].message_end = last;
        end
        foreach (batch[i]) begin
            expected_q.push_back(batch[i]);
        end
        return batch.size();
    endfunction

    // Compares one result transaction with the oldest expected result.
    function void check_result(logic [7:0] ob, logic re, logic me);
        t_morse_result exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, %s %h run_end %b message_end %b",
                     $time, "actual out_byte", ob, re, me);
            return;
        end
        exp_r = expected_q.pop_front();
        if (exp_r.out_byte !== ob) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %h, actual %h", $time, exp_r.out_byte, ob);
        end
        if (exp_r.run_end !== re) begin
            errors++;
            $display("%0t: run_end mismatch: expected %b, actual %b", $time, exp_r.run_end, re);
        end
        if (exp_r.message_end !== me) begin
            errors++;
            $display("%0t: message_end mismatch: expected %b, actual %b",
                     $time, exp_r.message_end, me);
        end
    endfunction
endclass

module tb;
    localparam int ITEM_TARGET   = 180;
    localparam int PHASE_ITEMS   = 25;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;

    logic i_clk;
    logic i_rst_n;

    mcc_in_if  in_ch ();
    mcc_out_if out_ch ();
    mcc_cfg_if cfg_ch ();

    t_morse_scoreboard sb;

    logic [7:0] msg_bytes [$];
    bit         no_idle;
    bit         hold_request;
    int         counted_items;

    morse_code_codec uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one byte, with an occasional idle gap first, and waits for its transaction.
    task automatic send_item(input logic [7:0] b, input logic l);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.last    <= l;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        void'(sb.note_byte(b, l));
        counted_items++;
    endtask

    task automatic send_message(input bit end_msg);
        foreach (msg_bytes[i]) begin
            send_item(msg_bytes[i], end_msg && (i == msg_bytes.size() - 1));
        end
    endtask

    // Stops offering bytes, waits for every expected result, then lets the block settle.
    task automatic wait_idle(input int settle);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic void load_text(string s);
        msg_bytes.delete();
        for (int i = 0; i < s.len(); i++) begin
            msg_bytes.push_back(s.getc(i));
        end
    endfunction

    // Random decode message: mostly real codes, some random paths, lone spaces
    // and stray bytes, tokens joined by separators.
    function automatic void build_decode_message();
        int tokens;
        int kind;
        int k;
        int n;
        msg_bytes.delete();
        tokens = $urandom_range(1, 5);
        for (int t = 0; t < tokens; t++) begin
            if (t > 0) begin
                msg_bytes.push_back(mcc_pkg::CH_SEP);
            end
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                k = $urandom_range(0, 52);
                for (int i = 0; i < sb.codes[k].len(); i++) begin
                    msg_bytes.push_back(sb.codes[k].getc(i));
                end
            end else if (kind < 8) begin
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) begin
                    msg_bytes.push_back($urandom_range(0, 1) ? mcc_pkg::CH_DASH
                                                             : mcc_pkg::CH_DOT);
                end
            end else if (kind == 8) begin
                msg_bytes.push_back(mcc_pkg::CH_SPACE);
            end else begin
                msg_bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    msg_bytes.push_back(mcc_pkg::CH_DOT);
                end
            end
        end
        if (msg_bytes.size() == 0 || $urandom_range(0, 3) == 0) begin
            msg_bytes.push_back(mcc_pkg::CH_SEP);
        end
    endfunction

    // Random text: table characters in either case, spaces and arbitrary bytes.
    function automatic void build_encode_message();
        int len;
        int kind;
        logic [7:0] c;
        msg_bytes.delete();
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 7);
            if (kind < 5) begin
                c = sb.symbols.getc($urandom_range(0, 52));
                if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) begin
                    c = c + mcc_pkg::CASE_STEP;
                end
            end else if (kind < 7) begin
                c = mcc_pkg::CH_SPACE;
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            msg_bytes.push_back(c);
        end
    endfunction

    // Result side: checks each result transaction and drives ready, with
    // random stalls and one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                sb.check_result(out_ch.out_byte, out_ch.run_end, out_ch.message_end);
            end
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (no_idle) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Ends the run when no transaction happens on any channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("morse_code_codec regression: fail");
        $finish;
    end

    // Main sequence: reset, directed messages, then random phases.
    initial begin : stimulus
        int phase;
        int phase_end;
        bit paused;
        sb            = new();
        no_idle       = 1'b0;
        hold_request  = 1'b0;
        counted_items = 0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        in_ch.last     <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.mode    <= mcc_pkg::MODE_DECODE;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Decode: a letter, an empty token, a lone space, an inner node, a stray
        // top byte, and a separator that also ends the message.
        write_mode(mcc_pkg::MODE_DECODE);
        load_text(".-__ _..--_");
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(mcc_pkg::CH_SEP);
        send_message(1'b1);
        // Path longer than seven symbols.
        load_text("........");
        send_message(1'b1);

        // Encode: lower case, the longest code after a separator, a space, NUL.
        wait_idle(SETTLE_CYCLES);
        write_mode(mcc_pkg::MODE_ENCODE);
        load_text("a$ ");
        msg_bytes.push_back(mcc_pkg::CH_NUL);
        send_message(1'b1);

        // Random phases alternate the mode; an unfinished message may carry
        // its state across a mode change.
        phase = 0;
        while (counted_items < ITEM_TARGET) begin
            wait_idle(SETTLE_CYCLES);
            write_mode(phase[0] ? mcc_pkg::MODE_DECODE : mcc_pkg::MODE_ENCODE);
            no_idle = (phase == 2);
            if (phase == 0) begin
                hold_request = 1'b1;
            end
            paused = 1'b0;
            phase_end = counted_items + PHASE_ITEMS;
            while (counted_items < phase_end && counted_items < ITEM_TARGET) begin
                if (sb.mode == mcc_pkg::MODE_ENCODE) begin
                    build_encode_message();
                end else begin
                    build_decode_message();
                end
                send_message($urandom_range(0, 9) != 0);
                if (phase == 3 && !paused) begin
                    wait_idle(1);
                    paused = 1'b1;
                end
            end
            phase++;
        end
        no_idle = 1'b0;

        wait_idle(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("morse_code_codec regression: pass");
        end else begin
            $display("morse_code_codec regression: fail");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_if.sv
hw/rtl/mcc_front.sv
hw/rtl/mcc_queue.sv
hw/rtl/mcc_back.sv
hw/rtl/morse_code_codec.sv
verif/tb.sv
